>>> rtl/core/c_subset_lexer_core_macros.svh
// Assertion helpers for the lexer core.
// Both expect aclk and aresetn in scope at the point of use.
`ifndef C_SUBSET_LEXER_CORE_MACROS_SVH
`define C_SUBSET_LEXER_CORE_MACROS_SVH

// Same-cycle implication
`define CLX_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define CLX_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/clx_pkg.sv
package clx_pkg;

    // Default parameter values
    localparam int KEYWORD_CHARS_DEFAULT  = 8;
    localparam int POSITION_WIDTH_DEFAULT = 16;

    // Token queue depth (entries of up to two tokens each)
    localparam int FIFO_DEPTH = 4;

    // Token kinds
    localparam logic [5:0] KIND_ID       = 6'd0;
    localparam logic [5:0] KIND_NUM      = 6'd1;
    localparam logic [5:0] KIND_KW_FIRST = 6'd2;
    localparam logic [5:0] KIND_PLUS     = 6'd10;
    localparam logic [5:0] KIND_MINUS    = 6'd11;
    localparam logic [5:0] KIND_STAR     = 6'd12;
    localparam logic [5:0] KIND_SLASH    = 6'd13;
    localparam logic [5:0] KIND_PCT      = 6'd14;
    localparam logic [5:0] KIND_BANG     = 6'd15;
    localparam logic [5:0] KIND_ANDAND   = 6'd16;
    localparam logic [5:0] KIND_OROR     = 6'd17;
    localparam logic [5:0] KIND_LT       = 6'd18;
    localparam logic [5:0] KIND_GT       = 6'd19;
    localparam logic [5:0] KIND_LE       = 6'd20;
    localparam logic [5:0] KIND_GE       = 6'd21;
    localparam logic [5:0] KIND_EQEQ     = 6'd22;
    localparam logic [5:0] KIND_NE       = 6'd23;
    localparam logic [5:0] KIND_ASSIGN   = 6'd24;
    localparam logic [5:0] KIND_LPAR     = 6'd25;
    localparam logic [5:0] KIND_RPAR     = 6'd26;
    localparam logic [5:0] KIND_LBR      = 6'd27;
    localparam logic [5:0] KIND_RBR      = 6'd28;
    localparam logic [5:0] KIND_SEMI     = 6'd29;
    localparam logic [5:0] KIND_COMMA    = 6'd30;
    localparam logic [5:0] KIND_EOF      = 6'd31;
    localparam logic [5:0] KIND_ERR      = 6'd32;

    // Error codes
    localparam logic [1:0] ERR_NONE = 2'd0;
    localparam logic [1:0] ERR_AMP  = 2'd1;
    localparam logic [1:0] ERR_BAR  = 2'd2;
    localparam logic [1:0] ERR_CHAR = 2'd3;

    // Character codes
    localparam logic [7:0] CH_NUL = 8'h00;
    localparam logic [7:0] CH_LF  = 8'h0A;

    // Keyword table, zero padded to the longest keyword
    localparam int KW_COUNT   = 8;
    localparam int KW_MAX_LEN = 8;

    localparam logic [7:0] KW_TEXT [KW_COUNT][KW_MAX_LEN] = '{
        '{"i", "n", "t", CH_NUL, CH_NUL, CH_NUL, CH_NUL, CH_NUL},
        '{"v", "o", "i", "d", CH_NUL, CH_NUL, CH_NUL, CH_NUL},
        '{"i", "f", CH_NUL, CH_NUL, CH_NUL, CH_NUL, CH_NUL, CH_NUL},
        '{"e", "l", "s", "e", CH_NUL, CH_NUL, CH_NUL, CH_NUL},
        '{"w", "h", "i", "l", "e", CH_NUL, CH_NUL, CH_NUL},
        '{"b", "r", "e", "a", "k", CH_NUL, CH_NUL, CH_NUL},
        '{"c", "o", "n", "t", "i", "n", "u", "e"},
        '{"r", "e", "t", "u", "r", "n", CH_NUL, CH_NUL}
    };

    localparam logic [7:0] KW_LEN [KW_COUNT] = '{
        8'd3, 8'd4, 8'd2, 8'd4, 8'd5, 8'd5, 8'd8, 8'd6
    };

    // Scanner states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_IDENT,
        ST_NUMBER,
        ST_MINUS,
        ST_SLASH,
        ST_BANG,
        ST_LT,
        ST_GT,
        ST_EQ,
        ST_AMP,
        ST_BAR,
        ST_LINECOM,
        ST_BLOCKCOM,
        ST_BLOCKSTAR
    } scan_state_t;

    // Token fields other than position
    typedef struct packed {
        logic [5:0] kind;
        logic [7:0] length;
        logic [1:0] err;
    } tok_info_t;

    localparam int TOK_INFO_W = $bits(tok_info_t);

    // Front to queue write control
    typedef struct packed {
        logic valid;
        logic pair;
    } push_ctl_t;

    // Queue status
    typedef struct packed {
        logic full;
        logic empty;
    } fifo_stat_t;

    // Kind of a single-character token that closes at once
    function automatic logic [5:0] punct_kind(input logic [7:0] ch);
        logic [5:0] k;
        case (ch)
            "+": k = KIND_PLUS;
            "*": k = KIND_STAR;
            "%": k = KIND_PCT;
            "(": k = KIND_LPAR;
            ")": k = KIND_RPAR;
            "{": k = KIND_LBR;
            "}": k = KIND_RBR;
            ";": k = KIND_SEMI;
            ",": k = KIND_COMMA;
            default: k = KIND_ERR;
        endcase
        return k;
    endfunction

endpackage

>>> rtl/core/clx_front.sv
module clx_front #(
    parameter int KEYWORD_CHARS  = clx_pkg::KEYWORD_CHARS_DEFAULT,
    parameter int POSITION_WIDTH = clx_pkg::POSITION_WIDTH_DEFAULT
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      take,
    input  logic [7:0]                text_byte,
    input  logic                      end_of_input,
    output clx_pkg::push_ctl_t        push_ctl,
    output clx_pkg::tok_info_t        first_info,
    output logic [POSITION_WIDTH-1:0] first_line,
    output logic [POSITION_WIDTH-1:0] first_col,
    output clx_pkg::tok_info_t        second_info,
    output logic [POSITION_WIDTH-1:0] second_line,
    output logic [POSITION_WIDTH-1:0] second_col
);

    localparam int IW = $clog2(KEYWORD_CHARS);
    localparam logic [POSITION_WIDTH-1:0] POS_ONE = POSITION_WIDTH'(1);
    localparam logic [POSITION_WIDTH-1:0] POS_MAX = {POSITION_WIDTH{1'b1}};

    typedef enum logic [1:0] {
        W_HOLD,
        W_ADD,
        W_START,
        W_MINUS
    } word_op_t;

    clx_pkg::scan_state_t state_reg, state_next;
    logic [7:0]                word_reg [KEYWORD_CHARS];
    logic [7:0]                run_reg;
    logic [POSITION_WIDTH-1:0] line_reg, col_reg;
    logic                      err_reg;

    logic                      eoi, is_digit, is_alpha, is_word, is_space, is_lf;
    logic                      op_start, eq_hit;
    logic [POSITION_WIDTH-1:0] line_adv, col_adv;
    logic [clx_pkg::KW_COUNT-1:0] kw_hit;
    logic [5:0]                kw_kind;

    logic                      consume, fall, err_set, pos_reset;
    word_op_t                  wop;

    logic                      t0_v, t0_adv, t1_v, t1_adv;
    clx_pkg::tok_info_t        t0, t1;

    // Byte classes
    assign eoi      = end_of_input || (text_byte == clx_pkg::CH_NUL);
    assign is_digit = text_byte inside {["0":"9"]};
    assign is_alpha = text_byte inside {["a":"z"], ["A":"Z"]};
    assign is_word  = is_alpha || is_digit || (text_byte == "_");
    assign is_space = (text_byte == " ") || (text_byte inside {[8'd9:8'd13]});
    assign is_lf    = (text_byte == clx_pkg::CH_LF);
    assign op_start = text_byte inside {"-", "/", "!", "<", ">", "=", "&", "|"};
    assign eq_hit   = !eoi && (text_byte == "=");

    // Position after consuming this byte, saturating
    always_comb begin
        line_adv = line_reg;
        col_adv  = col_reg;
        if (is_lf) begin
            if (line_reg != POS_MAX) line_adv = line_reg + POS_ONE;
            col_adv = POS_ONE;
        end else if (col_reg != POS_MAX) begin
            col_adv = col_reg + POS_ONE;
        end
    end

    // Keyword compare on the stored prefix
    always_comb begin
        for (int k = 0; k < clx_pkg::KW_COUNT; k++) begin
            kw_hit[k] = (run_reg == clx_pkg::KW_LEN[k]);
            for (int j = 0; j < clx_pkg::KW_MAX_LEN; j++) begin
                if (8'(j) < clx_pkg::KW_LEN[k] && word_reg[j] != clx_pkg::KW_TEXT[k][j])
                    kw_hit[k] = 1'b0;
            end
        end
        kw_kind = clx_pkg::KIND_ID;
        for (int k = clx_pkg::KW_COUNT - 1; k >= 0; k--) begin
            if (kw_hit[k]) kw_kind = clx_pkg::KIND_KW_FIRST + 6'(k);
        end
    end

    // Next state and datapath control
    always_comb begin
        state_next = state_reg;
        consume    = 1'b0;
        fall       = 1'b0;
        err_set    = 1'b0;
        pos_reset  = 1'b0;
        wop        = W_HOLD;
        case (state_reg)
            clx_pkg::ST_IDENT: begin
                if (!eoi && is_word) begin
                    consume = 1'b1;
                    wop     = W_ADD;
                end else begin
                    fall = 1'b1;
                end
            end
            clx_pkg::ST_NUMBER: begin
                if (!eoi && is_digit) begin
                    consume = 1'b1;
                    wop     = W_ADD;
                end else begin
                    fall = 1'b1;
                end
            end
            clx_pkg::ST_MINUS: begin
                if (!eoi && is_digit) begin
                    consume    = 1'b1;
                    wop        = W_MINUS;
                    state_next = clx_pkg::ST_NUMBER;
                end else begin
                    fall = 1'b1;
                end
            end
            clx_pkg::ST_SLASH: begin
                if (!eoi && text_byte == "/") begin
                    consume    = 1'b1;
                    state_next = clx_pkg::ST_LINECOM;
                end else if (!eoi && text_byte == "*") begin
                    consume    = 1'b1;
                    state_next = clx_pkg::ST_BLOCKCOM;
                end else begin
                    fall = 1'b1;
                end
            end
            clx_pkg::ST_BANG, clx_pkg::ST_LT, clx_pkg::ST_GT, clx_pkg::ST_EQ: begin
                if (eq_hit) begin
                    consume    = 1'b1;
                    state_next = clx_pkg::ST_IDLE;
                end else begin
                    fall = 1'b1;
                end
            end
            clx_pkg::ST_AMP: begin
                state_next = clx_pkg::ST_IDLE;
                if (!eoi && text_byte == "&") consume = 1'b1;
                else err_set = 1'b1;
            end
            clx_pkg::ST_BAR: begin
                state_next = clx_pkg::ST_IDLE;
                if (!eoi && text_byte == "|") consume = 1'b1;
                else err_set = 1'b1;
            end
            clx_pkg::ST_LINECOM: begin
                if (!eoi && !is_lf) consume = 1'b1;
                else fall = 1'b1;
            end
            clx_pkg::ST_BLOCKCOM: begin
                if (!eoi) begin
                    consume = 1'b1;
                    if (text_byte == "*") state_next = clx_pkg::ST_BLOCKSTAR;
                end else begin
                    fall = 1'b1;
                end
            end
            clx_pkg::ST_BLOCKSTAR: begin
                if (!eoi) begin
                    consume = 1'b1;
                    if (text_byte == "/") state_next = clx_pkg::ST_IDLE;
                    else if (text_byte != "*") state_next = clx_pkg::ST_BLOCKCOM;
                end else begin
                    fall = 1'b1;
                end
            end
            default: fall = 1'b1;
        endcase

        // Byte handled from the idle state
        if (fall) begin
            state_next = clx_pkg::ST_IDLE;
            if (eoi) begin
                pos_reset = 1'b1;
            end else begin
                consume = 1'b1;
                if (is_space) begin
                    state_next = clx_pkg::ST_IDLE;
                end else if (is_alpha || text_byte == "_") begin
                    wop        = W_START;
                    state_next = clx_pkg::ST_IDENT;
                end else if (is_digit) begin
                    wop        = W_START;
                    state_next = clx_pkg::ST_NUMBER;
                end else begin
                    case (text_byte)
                        "-": state_next = clx_pkg::ST_MINUS;
                        "/": state_next = clx_pkg::ST_SLASH;
                        "!": state_next = clx_pkg::ST_BANG;
                        "<": state_next = clx_pkg::ST_LT;
                        ">": state_next = clx_pkg::ST_GT;
                        "=": state_next = clx_pkg::ST_EQ;
                        "&": state_next = clx_pkg::ST_AMP;
                        "|": state_next = clx_pkg::ST_BAR;
                        default: err_set = (clx_pkg::punct_kind(text_byte) == clx_pkg::KIND_ERR);
                    endcase
                end
            end
        end
    end

    // Tokens: t0 closes the pending token, t1 comes from the idle-state handling
    always_comb begin
        t0_v   = 1'b0;
        t0_adv = 1'b0;
        t0     = '{kind: clx_pkg::KIND_ID, length: 8'd1, err: clx_pkg::ERR_NONE};
        t1_v   = 1'b0;
        t1_adv = 1'b0;
        t1     = '{kind: clx_pkg::KIND_EOF, length: 8'd0, err: clx_pkg::ERR_NONE};
        case (state_reg)
            clx_pkg::ST_IDENT: begin
                t0_v      = fall;
                t0.kind   = kw_kind;
                t0.length = run_reg;
            end
            clx_pkg::ST_NUMBER: begin
                t0_v      = fall;
                t0.kind   = clx_pkg::KIND_NUM;
                t0.length = run_reg;
            end
            clx_pkg::ST_MINUS: begin
                t0_v    = fall;
                t0.kind = clx_pkg::KIND_MINUS;
            end
            clx_pkg::ST_SLASH: begin
                t0_v    = fall;
                t0.kind = clx_pkg::KIND_SLASH;
            end
            clx_pkg::ST_BANG: begin
                t0_v    = 1'b1;
                t0.kind = eq_hit ? clx_pkg::KIND_NE : clx_pkg::KIND_BANG;
            end
            clx_pkg::ST_LT: begin
                t0_v    = 1'b1;
                t0.kind = eq_hit ? clx_pkg::KIND_LE : clx_pkg::KIND_LT;
            end
            clx_pkg::ST_GT: begin
                t0_v    = 1'b1;
                t0.kind = eq_hit ? clx_pkg::KIND_GE : clx_pkg::KIND_GT;
            end
            clx_pkg::ST_EQ: begin
                t0_v    = 1'b1;
                t0.kind = eq_hit ? clx_pkg::KIND_EQEQ : clx_pkg::KIND_ASSIGN;
            end
            clx_pkg::ST_AMP: begin
                t0_v = 1'b1;
                if (consume) begin
                    t0.kind = clx_pkg::KIND_ANDAND;
                end else begin
                    t0.kind = clx_pkg::KIND_ERR;
                    t0.err  = clx_pkg::ERR_AMP;
                end
            end
            clx_pkg::ST_BAR: begin
                t0_v = 1'b1;
                if (consume) begin
                    t0.kind = clx_pkg::KIND_OROR;
                end else begin
                    t0.kind = clx_pkg::KIND_ERR;
                    t0.err  = clx_pkg::ERR_BAR;
                end
            end
            default: t0_v = 1'b0;
        endcase

        // Two-character operators are stamped after their second character
        if (t0_v && !fall && consume) begin
            t0_adv    = 1'b1;
            t0.length = 8'd2;
        end

        if (fall) begin
            if (eoi) begin
                t1_v = 1'b1;
            end else if (!is_space && !is_alpha && !is_digit && text_byte != "_"
                         && !op_start) begin
                t1_v      = 1'b1;
                t1_adv    = 1'b1;
                t1.kind   = clx_pkg::punct_kind(text_byte);
                t1.length = 8'd1;
                t1.err    = (t1.kind == clx_pkg::KIND_ERR) ? clx_pkg::ERR_CHAR
                                                           : clx_pkg::ERR_NONE;
            end
        end
    end

    // Queue entry: first token is whichever exists, second only when both do
    assign push_ctl.valid = take && !err_reg && (t0_v || t1_v);
    assign push_ctl.pair  = t0_v && t1_v;
    assign first_info     = t0_v ? t0 : t1;
    assign first_line     = (t0_v ? t0_adv : t1_adv) ? line_adv : line_reg;
    assign first_col      = (t0_v ? t0_adv : t1_adv) ? col_adv : col_reg;
    assign second_info    = t1;
    assign second_line    = t1_adv ? line_adv : line_reg;
    assign second_col     = t1_adv ? col_adv : col_reg;

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= clx_pkg::ST_IDLE;
            run_reg   <= 8'd0;
            line_reg  <= POS_ONE;
            col_reg   <= POS_ONE;
            err_reg   <= 1'b0;
        end else if (take && !err_reg) begin
            state_reg <= state_next;
            if (err_set) err_reg <= 1'b1;
            if (pos_reset) begin
                line_reg <= POS_ONE;
                col_reg  <= POS_ONE;
            end else if (consume) begin
                line_reg <= line_adv;
                col_reg  <= col_adv;
            end
            case (wop)
                W_ADD:   if (run_reg != 8'hFF) run_reg <= run_reg + 8'd1;
                W_START: run_reg <= 8'd1;
                W_MINUS: run_reg <= 8'd2;
                default: run_reg <= run_reg;
            endcase
        end
    end

    // Word prefix buffer
    always_ff @(posedge aclk) begin
        if (take && !err_reg) begin
            case (wop)
                W_ADD: begin
                    if (run_reg < 8'(KEYWORD_CHARS)) word_reg[run_reg[IW-1:0]] <= text_byte;
                end
                W_START: begin
                    for (int i = 0; i < KEYWORD_CHARS; i++)
                        word_reg[i] <= (i == 0) ? text_byte : 8'h00;
                end
                W_MINUS: begin
                    for (int i = 0; i < KEYWORD_CHARS; i++)
                        word_reg[i] <= (i == 0) ? 8'("-") : ((i == 1) ? text_byte : 8'h00);
                end
                default: ;
            endcase
        end
    end

endmodule

>>> rtl/core/clx_fifo.sv
module clx_fifo #(
    parameter int WIDTH = 1,
    parameter int DEPTH = clx_pkg::FIFO_DEPTH
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  logic [WIDTH-1:0]    push_data,
    input  logic                pop,
    output logic [WIDTH-1:0]    pop_data,
    output clx_pkg::fifo_stat_t stat
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [AW:0]      count_reg;
    logic             do_push, do_pop;

    assign stat.full  = (count_reg == (AW + 1)'(DEPTH));
    assign stat.empty = (count_reg == '0);
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign pop_data   = slot_reg[rd_ptr_reg];

    // Pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) wr_ptr_reg <= (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + 1'b1;
            if (do_pop)  rd_ptr_reg <= (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)      count_reg <= count_reg + 1'b1;
            else if (do_pop && !do_push) count_reg <= count_reg - 1'b1;
        end
    end

    // Entry storage
    always_ff @(posedge aclk) begin
        if (do_push) slot_reg[wr_ptr_reg] <= push_data;
    end

endmodule

>>> rtl/core/clx_back.sv
module clx_back #(
    parameter int POSITION_WIDTH = clx_pkg::POSITION_WIDTH_DEFAULT
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  clx_pkg::fifo_stat_t       stat,
    output logic                      pop,
    input  logic                      head_pair,
    input  clx_pkg::tok_info_t        head_info0,
    input  logic [POSITION_WIDTH-1:0] head_line0,
    input  logic [POSITION_WIDTH-1:0] head_col0,
    input  clx_pkg::tok_info_t        head_info1,
    input  logic [POSITION_WIDTH-1:0] head_line1,
    input  logic [POSITION_WIDTH-1:0] head_col1,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [5:0]                m_token_kind,
    output logic [7:0]                m_token_length,
    output logic [POSITION_WIDTH-1:0] m_line_number,
    output logic [POSITION_WIDTH-1:0] m_column_number,
    output logic [1:0]                m_error_code,
    output logic                      m_last_of_run
);

    logic                      out_valid_reg, sec_pend_reg;
    clx_pkg::tok_info_t        out_info_reg, sec_info_reg;
    logic [POSITION_WIDTH-1:0] out_line_reg, out_col_reg, sec_line_reg, sec_col_reg;
    logic                      out_last_reg;
    logic                      load;

    // Output register free or draining this cycle
    assign load = !out_valid_reg || m_ready;
    assign pop  = load && !sec_pend_reg && !stat.empty;

    // Control: output valid and held second token
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            sec_pend_reg  <= 1'b0;
        end else if (load) begin
            if (sec_pend_reg) begin
                out_valid_reg <= 1'b1;
                sec_pend_reg  <= 1'b0;
            end else begin
                out_valid_reg <= !stat.empty;
                sec_pend_reg  <= !stat.empty && head_pair;
            end
        end
    end

    // Payload
    always_ff @(posedge aclk) begin
        if (load) begin
            if (sec_pend_reg) begin
                out_info_reg <= sec_info_reg;
                out_line_reg <= sec_line_reg;
                out_col_reg  <= sec_col_reg;
                out_last_reg <= 1'b1;
            end else if (!stat.empty) begin
                out_info_reg <= head_info0;
                out_line_reg <= head_line0;
                out_col_reg  <= head_col0;
                out_last_reg <= !head_pair;
                sec_info_reg <= head_info1;
                sec_line_reg <= head_line1;
                sec_col_reg  <= head_col1;
            end
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_token_kind    = out_info_reg.kind;
    assign m_token_length  = out_info_reg.length;
    assign m_line_number   = out_line_reg;
    assign m_column_number = out_col_reg;
    assign m_error_code    = out_info_reg.err;
    assign m_last_of_run   = out_last_reg;

endmodule

>>> rtl/core/c_subset_lexer_core.sv
// Streaming lexer for a small C subset. The scanner takes one text byte per cycle
// whenever the four-entry token queue has room, so s_ready drops only when the
// queue fills; each byte is classified and the token it closes is formed in the
// same cycle. The output stage sends one token per cycle while m_ready is high, so
// a byte that closes two tokens (a pending token plus a one-character token or EOF)
// holds the second one in the output stage before the next queue pop; the sustained
// rate is one byte per cycle for text that closes at most one token per byte. A token
// passes through the token queue and then the output register before it reaches m_valid.
// After an error token the block keeps accepting bytes but produces nothing until reset.
`include "c_subset_lexer_core_macros.svh"

module c_subset_lexer_core #(
    parameter int KEYWORD_CHARS  = clx_pkg::KEYWORD_CHARS_DEFAULT,
    parameter int POSITION_WIDTH = clx_pkg::POSITION_WIDTH_DEFAULT
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [7:0]                s_text_byte,
    input  logic                      s_end_of_input,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [5:0]                m_token_kind,
    output logic [7:0]                m_token_length,
    output logic [POSITION_WIDTH-1:0] m_line_number,
    output logic [POSITION_WIDTH-1:0] m_column_number,
    output logic [1:0]                m_error_code,
    output logic                      m_last_of_run
);

    localparam int ENTRY_W = 1 + 2 * (clx_pkg::TOK_INFO_W + 2 * POSITION_WIDTH);

    clx_pkg::push_ctl_t        push_ctl;
    clx_pkg::fifo_stat_t       fifo_stat;
    clx_pkg::tok_info_t        f_info0, f_info1, h_info0, h_info1;
    logic [POSITION_WIDTH-1:0] f_line0, f_col0, f_line1, f_col1;
    logic [POSITION_WIDTH-1:0] h_line0, h_col0, h_line1, h_col1;
    logic                      h_pair, take, pop;
    logic [ENTRY_W-1:0]        wr_data, rd_data;
    logic                      tok_err, tok_eof, err_ok, eof_ok, code_ok;

    assign s_ready = !fifo_stat.full;
    assign take    = s_valid && s_ready;

    // Scanner
    clx_front #(
        .KEYWORD_CHARS  (KEYWORD_CHARS),
        .POSITION_WIDTH (POSITION_WIDTH)
    ) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .take         (take),
        .text_byte    (s_text_byte),
        .end_of_input (s_end_of_input),
        .push_ctl     (push_ctl),
        .first_info   (f_info0),
        .first_line   (f_line0),
        .first_col    (f_col0),
        .second_info  (f_info1),
        .second_line  (f_line1),
        .second_col   (f_col1)
    );

    // Token queue
    assign wr_data = {push_ctl.pair, f_info0, f_line0, f_col0, f_info1, f_line1, f_col1};
    assign {h_pair, h_info0, h_line0, h_col0, h_info1, h_line1, h_col1} = rd_data;

    clx_fifo #(
        .WIDTH (ENTRY_W),
        .DEPTH (clx_pkg::FIFO_DEPTH)
    ) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push_ctl.valid),
        .push_data (wr_data),
        .pop       (pop),
        .pop_data  (rd_data),
        .stat      (fifo_stat)
    );

    // Output serializer
    clx_back #(
        .POSITION_WIDTH (POSITION_WIDTH)
    ) u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .stat            (fifo_stat),
        .pop             (pop),
        .head_pair       (h_pair),
        .head_info0      (h_info0),
        .head_line0      (h_line0),
        .head_col0       (h_col0),
        .head_info1      (h_info1),
        .head_line1      (h_line1),
        .head_col1       (h_col1),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_token_kind    (m_token_kind),
        .m_token_length  (m_token_length),
        .m_line_number   (m_line_number),
        .m_column_number (m_column_number),
        .m_error_code    (m_error_code),
        .m_last_of_run   (m_last_of_run)
    );

    // Shape of the token on the output
    assign tok_err = m_valid && (m_token_kind == clx_pkg::KIND_ERR);
    assign tok_eof = m_valid && (m_token_kind == clx_pkg::KIND_EOF);
    assign err_ok  = m_last_of_run && (m_token_length == 8'd1)
                     && (m_error_code != clx_pkg::ERR_NONE);
    assign eof_ok  = m_last_of_run && (m_token_length == 8'd0)
                     && (m_error_code == clx_pkg::ERR_NONE);
    assign code_ok = tok_err || (m_error_code == clx_pkg::ERR_NONE);

    // Error token is one character wide and closes its run
    `CLX_ASSERT_IMP(a_err_shape, tok_err, err_ok, "malformed error token")
    // EOF is empty, error free and closes its run
    `CLX_ASSERT_IMP(a_eof_shape, tok_eof, eof_ok, "malformed EOF token")
    // Error code only on error tokens
    `CLX_ASSERT_IMP(a_code_on_err, m_valid, code_ok, "error code on a regular token")
    // Nothing follows a delivered error token
    `CLX_ASSERT_NXT(a_err_final, tok_err && m_ready, !m_valid, "token after error")

endmodule
